>>> src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the streaming find-and-replace
// Item structs, cell control structs, register indexes and length helpers.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int PAT_MAX  = 8;
  localparam int REPL_MAX = 8;
  localparam int IDX_W    = $clog2(PAT_MAX);
  localparam int LEN_W    = $clog2(PAT_MAX + 1);

  // configuration register indexes
  localparam logic [2:0] REG_PAT_BYTES  = 3'd0;
  localparam logic [2:0] REG_PAT_LEN    = 3'd1;
  localparam logic [2:0] REG_REPL_BYTES = 3'd2;
  localparam logic [2:0] REG_REPL_LEN   = 3'd3;
  localparam logic [2:0] REG_CAPACITY   = 3'd4;

  localparam logic [3:0] PAT_LEN_RST  = 4'd1;
  localparam logic [7:0] CAPACITY_RST = 8'd50;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       out_last;
    logic [7:0] repl_count;
    logic       overflow;
  } out_item_t;

  // window cell control, shared by every cell
  typedef struct packed {
    logic upd;
    logic shift;
  } win_ctl_t;

  // output queue cell control
  typedef struct packed {
    logic load;
    logic pop;
  } oq_ctl_t;

  function automatic logic [LEN_W-1:0] eff_pat_len(input logic [3:0] raw);
    logic [LEN_W-1:0] l;
    if (raw == 4'd0) begin
      l = LEN_W'(1);
    end else if (raw > 4'(PAT_MAX)) begin
      l = LEN_W'(PAT_MAX);
    end else begin
      l = LEN_W'(raw);
    end
    return l;
  endfunction

  function automatic logic [3:0] eff_repl_len(input logic [3:0] raw);
    return (raw > 4'(REPL_MAX)) ? 4'(REPL_MAX) : raw;
  endfunction

endpackage

>>> src/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace: streaming find-and-replace on a text byte stream
// Replaces leftmost, non-overlapping pattern occurrences with a replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_stall/in_data) carry one text byte and a last
//   marker. Result items (out_valid/out_stall/out_data) carry emitted bytes,
//   the running replacement count and the sticky overflow flag of the string.
//   Registers are written on cfg_valid (cfg_ready is always high); the user
//   must write them only while idle; the block itself does not enforce it.
// Results of an item appear in the cycle after it is accepted; one item per
//   cycle is taken while each yields at most one result and the receiver
//   does not stall. An n-result item (replacement burst or end-of-string
//   flush, up to 8) keeps in_stall high until the last is being taken.
// Matching: a row of 8 window cells compares the pending bytes plus the new
//   byte against the pattern in the cycle the byte is accepted.
// Reset: queue empty, window empty, counters cleared, registers at defaults.
// Receiver stall: the result at the head holds; once the queue can no
//   longer take the next burst, in_stall rises. Queue: a row of 8 byte cells.
// ----------------------------------------------------------------------------
module stream_find_replace
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration
  logic [63:0] pat_r;
  logic [3:0]  plen_r;
  logic [63:0] repl_r;
  logic [3:0]  rlen_r;
  logic [7:0]  cap_r;

  // string state
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [7:0]       emit_r, emit_nxt;
  logic [7:0]       mt_r, mt_nxt;
  logic             ovf_r, ovf_nxt;

  // result queue
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             last_r;
  logic             present_r;
  logic [7:0]       qmt_r;
  logic             qovf_r;

  logic             cfg_we;
  logic             accept;
  logic             pop;
  logic [LEN_W-1:0] len_eff;
  logic [3:0]       rl_eff;
  logic [IDX_W-1:0] fill_cur;
  logic [LEN_W-1:0] f1;
  logic             full;
  logic             hit;
  logic [3:0]       n_try;
  logic [7:0]       room;
  logic [3:0]       k;
  logic             drop;
  logic [7:0]       mt_step;
  logic             ovf_step;
  logic [LEN_W-1:0] n_out;

  win_ctl_t         wctl;
  oq_ctl_t          qctl;
  logic [7:0]       cand [PAT_MAX];
  logic [PAT_MAX-1:0] eq;
  logic [7:0]       qbyte [PAT_MAX];

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign len_eff  = eff_pat_len(plen_r);
  assign rl_eff   = eff_repl_len(rlen_r);
  assign fill_cur = ({1'b0, fill_r} >= len_eff) ? '0 : fill_r;
  assign f1       = LEN_W'(fill_cur) + LEN_W'(1);
  assign full     = (f1 == len_eff);
  assign hit      = full && (&eq);

  // bytes the step tries to emit, then clipped to the remaining capacity
  always_comb begin
    if (hit) begin
      n_try = rl_eff;
    end else if (in_data.in_last) begin
      n_try = 4'(f1);
    end else if (full) begin
      n_try = 4'd1;
    end else begin
      n_try = 4'd0;
    end
  end

  assign room     = (emit_r < cap_r) ? (cap_r - emit_r) : 8'd0;
  assign drop     = ({4'd0, n_try} > room);
  assign k        = drop ? room[3:0] : n_try;
  assign mt_step  = (hit && (mt_r != 8'hFF)) ? (mt_r + 8'd1) : mt_r;
  assign ovf_step = ovf_r | drop;
  assign n_out    = (in_data.in_last && (k == 4'd0)) ? LEN_W'(1) : LEN_W'(k);

  // queue handshake
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == '0) || ((cnt_r == LEN_W'(1)) && pop));
  assign accept    = in_valid && !in_stall;

  assign wctl.upd   = accept;
  assign wctl.shift = full && !hit;
  assign qctl.load  = accept && (n_out != '0);
  assign qctl.pop   = pop;

  genvar gi;
  generate
    for (gi = 0; gi < PAT_MAX; gi++) begin : g_win
      sfr_win_cell u_cell (
        .clk        (clk),
        .ctl        (wctl),
        .load_sel   (fill_cur == IDX_W'(gi)),
        .active     (LEN_W'(gi) < len_eff),
        .in_byte    (in_data.in_byte),
        .pat_byte   (pat_r[8*gi +: 8]),
        .right_byte ((gi == PAT_MAX-1) ? cand[gi] : cand[(gi+1) % PAT_MAX]),
        .cand_byte  (cand[gi]),
        .eq         (eq[gi])
      );
    end
    for (gi = 0; gi < PAT_MAX; gi++) begin : g_out
      sfr_out_cell u_cell (
        .clk        (clk),
        .ctl        (qctl),
        .load_byte  (hit ? repl_r[8*gi +: 8] : cand[gi]),
        .right_byte ((gi == PAT_MAX-1) ? 8'd0 : qbyte[(gi+1) % PAT_MAX]),
        .data_byte  (qbyte[gi])
      );
    end
  endgenerate

  always_comb begin
    fill_nxt = fill_r;
    emit_nxt = emit_r;
    mt_nxt   = mt_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      if (in_data.in_last) begin
        fill_nxt = '0;
        emit_nxt = '0;
        mt_nxt   = '0;
        ovf_nxt  = 1'b0;
      end else begin
        priority if (hit) begin
          fill_nxt = '0;
        end else if (full) begin
          fill_nxt = IDX_W'(len_eff - LEN_W'(1));
        end else begin
          fill_nxt = IDX_W'(f1);
        end
        emit_nxt = emit_r + {4'd0, k};
        mt_nxt   = mt_step;
        ovf_nxt  = ovf_step;
      end
    end else if (cfg_we && (cfg_index == REG_PAT_LEN)) begin
      // shorter pattern: drop all pending bytes once they no longer fit
      if ({1'b0, fill_r} >= eff_pat_len(cfg_data[3:0])) begin
        fill_nxt = '0;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (qctl.load) begin
      cnt_nxt = n_out;
    end else if (pop) begin
      cnt_nxt = cnt_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= PAT_LEN_RST;
      repl_r <= '0;
      rlen_r <= '0;
      cap_r  <= CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_BYTES:  pat_r  <= cfg_data;
        REG_PAT_LEN:    plen_r <= cfg_data[3:0];
        REG_REPL_BYTES: repl_r <= cfg_data;
        REG_REPL_LEN:   rlen_r <= cfg_data[3:0];
        REG_CAPACITY:   cap_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      emit_r <= '0;
      mt_r   <= '0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      emit_r <= emit_nxt;
      mt_r   <= mt_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.load) begin
      last_r    <= in_data.in_last;
      present_r <= (k != 4'd0);
      qmt_r     <= mt_step;
      qovf_r    <= ovf_step;
    end
  end

  assign out_data.out_byte     = present_r ? qbyte[0] : 8'd0;
  assign out_data.byte_present = present_r;
  assign out_data.out_last     = last_r && (cnt_r == LEN_W'(1));
  assign out_data.repl_count   = qmt_r;
  assign out_data.overflow     = qovf_r;

endmodule

>>> src/sfr_win_cell.sv
// ----------------------------------------------------------------------------
// sfr_win_cell: one pending-byte slot of the match window
// Holds one byte, takes the incoming byte when selected, compares against its
// pattern byte and shifts toward the oldest slot on a full-window mismatch.
// ----------------------------------------------------------------------------
module sfr_win_cell
  import sfr_pkg::*;
(
  input  logic     clk,
  input  win_ctl_t ctl,
  input  logic     load_sel,
  input  logic     active,
  input  logic [7:0] in_byte,
  input  logic [7:0] pat_byte,
  input  logic [7:0] right_byte,
  output logic [7:0] cand_byte,
  output logic       eq
);

  logic [7:0] win_r;
  logic [7:0] win_nxt;

  assign cand_byte = load_sel ? in_byte : win_r;
  // slots past the pattern length never block a match
  assign eq        = !active || (cand_byte == pat_byte);
  assign win_nxt   = ctl.shift ? right_byte : cand_byte;

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      win_r <= win_nxt;
    end
  end

endmodule

>>> src/sfr_out_cell.sv
// ----------------------------------------------------------------------------
// sfr_out_cell: one slot of the result byte queue
// Loads a burst byte in parallel and shifts toward slot 0 on each pop.
// ----------------------------------------------------------------------------
module sfr_out_cell
  import sfr_pkg::*;
(
  input  logic       clk,
  input  oq_ctl_t    ctl,
  input  logic [7:0] load_byte,
  input  logic [7:0] right_byte,
  output logic [7:0] data_byte
);

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= load_byte;
    end else if (ctl.pop) begin
      data_r <= right_byte;
    end
  end

  assign data_byte = data_r;

endmodule

>>> src/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks on the result channel
// Watches the result handshake and the end-of-string marker.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result item changed while stalled");

  // a bare end marker only ever closes a string and carries a zero byte
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_present |-> out_data.out_last && (out_data.out_byte == 8'd0))
    else $error("bare item is not a clean end marker");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result channel not empty after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

>>> verif/stream_find_replace_tb.sv
// ----------------------------------------------------------------------------
// stream_find_replace_tb: self-checking bench for the streaming find-and-replace
// Drives text items through the block, predicts each emitted item from its own
// model of the window, counters and registers, and checks every result item in
// order. Registers change only while the block is idle, between phases.
// ----------------------------------------------------------------------------
module stream_find_replace_tb;
  import sfr_pkg::*;

  localparam int HOLD_AFTER    = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int STUCK_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int RANDOM_ITEMS  = 200;
  localparam int LONG_AFTER    = 100;
  localparam int LONG_RUN      = 270;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_PAT_BYTES;
  logic [63:0] cfg_data  = '0;

  stream_find_replace dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // text items waiting for the driver, result items still due
  in_item_t    pending_bytes [$];
  out_item_t   expected_emits [$];
  out_item_t   due_item;
  int          queued_total = 0;
  int          in_accepted  = 0;
  int          random_items = 0;
  int          failures     = 0;
  int          stuck_cycles = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;

  // model copy of registers and string state
  logic [63:0] pat_word      = '0;
  logic [3:0]  pat_len_raw   = PAT_LEN_RST;
  logic [63:0] repl_word     = '0;
  logic [3:0]  repl_len_raw  = '0;
  logic [7:0]  cap_limit     = CAPACITY_RST;
  logic [7:0]  win_bytes [PAT_MAX];
  int unsigned win_fill      = 0;
  int unsigned emitted_total = 0;
  logic [7:0]  match_total   = '0;
  logic        ovf_flag      = 1'b0;
  logic [7:0]  step_bytes [$];

  function automatic int unsigned active_pat_len();
    int unsigned l;
    l = pat_len_raw;
    if (l == 0) l = 1;
    if (l > PAT_MAX) l = PAT_MAX;
    return l;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    if (emitted_total < cap_limit) begin
      step_bytes.push_back(b);
      emitted_total++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  function automatic void replace_step(in_item_t it);
    int unsigned plen;
    int unsigned rlen;
    logic        hit;
    out_item_t   res;
    plen = active_pat_len();
    step_bytes.delete();
    if (win_fill >= plen) win_fill = 0;
    win_bytes[win_fill] = it.in_byte;
    win_fill++;
    if (win_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (win_bytes[i] != pat_word[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        rlen = (repl_len_raw > REPL_MAX) ? REPL_MAX : repl_len_raw;
        for (int i = 0; i < rlen; i++) emit_byte(repl_word[8*i +: 8]);
        win_fill = 0;
        if (match_total != 8'hFF) match_total++;
      end else begin
        emit_byte(win_bytes[0]);
        for (int i = 1; i < plen; i++) win_bytes[i-1] = win_bytes[i];
        win_fill = plen - 1;
      end
    end
    if (it.in_last) begin
      for (int i = 0; i < win_fill; i++) emit_byte(win_bytes[i]);
      win_fill = 0;
    end
    // every item of one step carries the count and flag as they end the step
    foreach (step_bytes[i]) begin
      res.out_byte     = step_bytes[i];
      res.byte_present = 1'b1;
      res.out_last     = it.in_last && (i == step_bytes.size() - 1);
      res.repl_count   = match_total;
      res.overflow     = ovf_flag;
      expected_emits.push_back(res);
    end
    if (it.in_last && step_bytes.size() == 0) begin
      res            = '0;
      res.out_last   = 1'b1;
      res.repl_count = match_total;
      res.overflow   = ovf_flag;
      expected_emits.push_back(res);
    end
    if (it.in_last) begin
      emitted_total = 0;
      match_total   = '0;
      ovf_flag      = 1'b0;
    end
  endfunction

  function automatic bit quiet_stretch();
    return in_accepted >= 300 && in_accepted < 420;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      failures++;
    end
  endfunction

  function automatic void push_byte(logic [7:0] b, logic last);
    pending_bytes.push_back('{in_byte: b, in_last: last});
    queued_total++;
  endfunction

  // text drawn mostly from the pattern itself so matches and near misses occur
  function automatic void queue_string(int unsigned n, bit closed);
    int unsigned plen;
    int unsigned cut;
    logic [7:0]  text [$];
    plen = active_pat_len();
    while (text.size() < n) begin
      case ($urandom_range(0, 3))
        0: begin
          cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
          for (int j = 0; j < cut; j++) text.push_back(pat_word[8*j +: 8]);
        end
        1: begin
          cut = $urandom_range(0, plen - 1);
          text.push_back(pat_word[8*cut +: 8]);
        end
        2: text.push_back(8'($urandom));
        default: text.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
      endcase
    end
    foreach (text[i]) push_byte(text[i], closed && (i == text.size() - 1));
    random_items += text.size();
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PAT_BYTES:  pat_word = value;
      REG_PAT_LEN: begin
        pat_len_raw = value[3:0];
        if (win_fill >= active_pat_len()) win_fill = 0;
      end
      REG_REPL_BYTES: repl_word = value;
      REG_REPL_LEN:   repl_len_raw = value[3:0];
      REG_CAPACITY:   cap_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (in_accepted != queued_total || expected_emits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int unsigned pick;
    logic [3:0]  len;
    logic [7:0]  cap;
    if ($urandom_range(0, 2) == 0) write_reg(REG_PAT_BYTES, {$urandom, $urandom});
    if ($urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, 9);
      len = (pick < 6) ? 4'($urandom_range(1, 4)) : (pick < 8) ? 4'(PAT_MAX) : 4'($urandom);
      write_reg(REG_PAT_LEN, {$urandom, 28'($urandom), len});
    end
    if ($urandom_range(0, 2) == 0) write_reg(REG_REPL_BYTES, {$urandom, $urandom});
    if ($urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, 9);
      len = (pick < 8) ? 4'($urandom_range(0, REPL_MAX)) : 4'($urandom);
      write_reg(REG_REPL_LEN, {$urandom, 28'($urandom), len});
    end
    if ($urandom_range(0, 3) == 0) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       cap = 8'd0;
        1:       cap = 8'd1;
        2, 3:    cap = 8'($urandom_range(2, 12));
        4, 5:    cap = 8'hFF;
        default: cap = 8'($urandom_range(13, 254));
      endcase
      write_reg(REG_CAPACITY, {$urandom, 24'($urandom), cap});
    end
    if ($urandom_range(0, 15) == 0) begin
      write_reg(REG_CAPACITY + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    end
  endtask

  // driver: next text item goes out once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replace_step(in_data);
        in_accepted <= in_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && (quiet_stretch() || $urandom_range(0, 99) >= 25)) begin
          in_data  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_accepted >= HOLD_AFTER && pending_bytes.size() >= 16) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_stretch() && ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_emits.size() == 0) begin
        $error("unexpected result item: %p", out_data);
        failures++;
      end else begin
        due_item = expected_emits.pop_front();
        check_field("out_byte", due_item.out_byte, out_data.out_byte);
        check_field("byte_present", 8'(due_item.byte_present), 8'(out_data.byte_present));
        check_field("out_last", 8'(due_item.out_last), 8'(out_data.out_last));
        check_field("repl_count", due_item.repl_count, out_data.repl_count);
        check_field("overflow", 8'(due_item.overflow), 8'(out_data.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("stream_find_replace: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned strings;
    bit          long_done;
    long_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: a zero byte is deleted; the string ends on a deleted byte,
    // so it closes with a bare end marker
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // "ABC" becomes eight bytes; then a near miss flushed at end of string
    write_reg(REG_PAT_BYTES, 64'h0000_0000_0043_4241);
    write_reg(REG_PAT_LEN, 64'd3);
    write_reg(REG_REPL_BYTES, 64'hFE01_DC23_BA45_9867);
    write_reg(REG_REPL_LEN, 64'd8);
    write_reg(REG_CAPACITY, 64'd255);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h43, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h58, 1'b1);
    wait_idle();

    // pattern length zero acts as one, replacement length past eight as eight
    write_reg(REG_PAT_LEN, 64'd0);
    write_reg(REG_REPL_LEN, 64'd12);
    push_byte(8'h41, 1'b1);
    wait_idle();

    // pattern length past the maximum acts as the maximum
    write_reg(REG_PAT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PAT_LEN, 64'd15);
    for (int i = 0; i < PAT_MAX; i++) push_byte(8'hFF, i == PAT_MAX - 1);
    wait_idle();

    // zero capacity: all data dropped, overflow rides on the end marker
    write_reg(REG_CAPACITY, 64'd0);
    push_byte(8'h10, 1'b0);
    push_byte(8'h20, 1'b1);
    wait_idle();

    // shortening the pattern below the pending fill discards the window
    write_reg(REG_CAPACITY, 64'd20);
    write_reg(REG_PAT_BYTES, 64'h0000_0000_7A79_7877);
    write_reg(REG_PAT_LEN, 64'd4);
    push_byte(8'h77, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h79, 1'b0);
    wait_idle();
    write_reg(REG_PAT_LEN, 64'd2);
    push_byte(8'h71, 1'b1);
    wait_idle();

    // index past the register list writes nothing
    write_reg(REG_CAPACITY + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);

    while (random_items < RANDOM_ITEMS) begin
      random_config();
      strings = $urandom_range(1, 3);
      for (int s = 0; s < strings; s++) begin
        // a phase sometimes stops mid-string so the next settings meet pending window bytes
        queue_string(($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16),
                     (s < strings - 1) || ($urandom_range(0, 4) != 0));
      end
      wait_idle();
      if (!long_done && random_items >= LONG_AFTER) begin
        // one long string: count saturates and capacity runs out
        long_done = 1'b1;
        write_reg(REG_PAT_BYTES, {$urandom, $urandom});
        write_reg(REG_PAT_LEN, 64'd1);
        write_reg(REG_REPL_LEN, 64'd1);
        write_reg(REG_CAPACITY, 64'd255);
        for (int i = 0; i < LONG_RUN; i++) push_byte(pat_word[7:0], i == LONG_RUN - 1);
        wait_idle();
      end
    end
    push_byte(8'($urandom), 1'b1);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_emits.size() != 0) begin
      $error("%0d result items never arrived", expected_emits.size());
      failures++;
    end
    if (failures == 0) begin
      $display("stream_find_replace: match");
    end else begin
      $display("stream_find_replace: mismatch");
    end
    $finish;
  end

endmodule
